[rtl/pafit_pkg.sv]
`default_nettype none
package pafit_pkg;

  localparam int unsigned ENTRIES   = 32;
  localparam int unsigned ADDR_BITS = 32;
  localparam int unsigned IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OWN_W     = 16;
  localparam int unsigned FLD_W     = 32;

  // request op codes
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_ADD     = 2'd1;
  localparam logic [1:0] OP_ALLOC   = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  // fit policies (the unused code behaves as first fit)
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_NOBUSY = 2'd3;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef enum logic [2:0] {
    TC_NONE,
    TC_CLEAR,
    TC_FILL,
    TC_TAKE,
    TC_FREE,
    TC_RESIZE,
    TC_MERGE
  } tcmd_e;

  typedef struct packed {
    tcmd_e             op;
    idx_t              idx;
    idx_t              drop_idx;
    logic              busy;
    logic [OWN_W-1:0]  owner;
    addr_t             start;
    addr_t             len;
  } tbl_cmd_t;

  typedef struct packed {
    logic              valid;
    logic              busy;
    logic [OWN_W-1:0]  owner;
    addr_t             start;
    addr_t             len;
  } tbl_ent_t;

endpackage
`default_nettype wire

[rtl/pafit_req_if.sv]
`default_nettype none
interface pafit_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [1:0]  policy;
  logic [15:0] owner;
  logic [31:0] start_address;
  logic [31:0] request_size;

  modport source (output valid, op, policy, owner, start_address, request_size,
                  input ready);
  modport sink   (input valid, op, policy, owner, start_address, request_size,
                  output ready);
endinterface
`default_nettype wire

[rtl/pafit_rsp_if.sv]
`default_nettype none
interface pafit_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] alloc_address;

  modport source (output valid, status, alloc_address, input ready);
  modport sink   (input valid, status, alloc_address, output ready);
endinterface
`default_nettype wire

[rtl/pafit_table.sv]
`default_nettype none
module pafit_table
  import pafit_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire tbl_cmd_t cmd_i,
  input  wire idx_t     rd_idx_i,
  output tbl_ent_t      rd_o,
  output idx_t          free_idx_o,
  output logic          has_free_o,
  output logic          any_busy_o
);

  logic [ENTRIES-1:0] valid_q;
  logic [ENTRIES-1:0] busy_q;
  logic [OWN_W-1:0]   owner_q [ENTRIES];
  addr_t              start_q [ENTRIES];
  addr_t              len_q   [ENTRIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      busy_q  <= '0;
    end else begin
      case (cmd_i.op)
        TC_CLEAR: begin
          valid_q <= '0;
          busy_q  <= '0;
        end
        TC_FILL: begin
          valid_q[cmd_i.idx] <= 1'b1;
          busy_q[cmd_i.idx]  <= cmd_i.busy;
        end
        TC_TAKE:  busy_q[cmd_i.idx] <= 1'b1;
        TC_FREE:  busy_q[cmd_i.idx] <= 1'b0;
        TC_MERGE: valid_q[cmd_i.drop_idx] <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      TC_FILL: begin
        owner_q[cmd_i.idx] <= cmd_i.owner;
        start_q[cmd_i.idx] <= cmd_i.start;
        len_q[cmd_i.idx]   <= cmd_i.len;
      end
      TC_TAKE: owner_q[cmd_i.idx] <= cmd_i.owner;
      TC_RESIZE, TC_MERGE: begin
        start_q[cmd_i.idx] <= cmd_i.start;
        len_q[cmd_i.idx]   <= cmd_i.len;
      end
      default: ;
    endcase
  end

  always_comb begin
    rd_o.valid = valid_q[rd_idx_i];
    rd_o.busy  = busy_q[rd_idx_i];
    rd_o.owner = owner_q[rd_idx_i];
    rd_o.start = start_q[rd_idx_i];
    rd_o.len   = len_q[rd_idx_i];
  end

  // lowest invalid entry
  always_comb begin
    free_idx_o = '0;
    has_free_o = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx_o = IDX_W'(i);
        has_free_o = 1'b1;
      end
    end
  end

  assign any_busy_o = |(valid_q & busy_q);

endmodule
`default_nettype wire

[rtl/pafit_judge.sv]
`default_nettype none
module pafit_judge
  import pafit_pkg::*;
(
  input  wire logic       alloc_i,
  input  wire logic [1:0] policy_i,
  input  wire tbl_ent_t   ent_i,
  input  wire idx_t       idx_i,
  input  wire addr_t      size_i,
  input  wire logic       bound_i,
  input  wire addr_t      last_start_i,
  input  wire idx_t       last_idx_i,
  input  wire logic       have_i,
  input  wire addr_t      pick_start_i,
  input  wire addr_t      pick_len_i,
  output logic            take_o
);

  logic is_free;
  logic elig;
  logic better;

  assign is_free = ent_i.valid && !ent_i.busy;

  always_comb begin
    if (alloc_i) begin
      elig = is_free && (ent_i.len >= size_i);
      case (policy_i)
        POL_BEST:  better = ent_i.len < pick_len_i;
        POL_WORST: better = ent_i.len > pick_len_i;
        default:   better = ent_i.start < pick_start_i;
      endcase
    end else begin
      // successor of the last visited (start, index) key
      elig   = is_free && (!bound_i || (ent_i.start > last_start_i) ||
               ((ent_i.start == last_start_i) && (idx_i > last_idx_i)));
      better = ent_i.start < pick_start_i;
    end
  end

  assign take_o = elig && (!have_i || better);

endmodule
`default_nettype wire

[rtl/partition_allocator_fit_unit.sv]
`default_nettype none
// segment table allocator: keeps ENTRIES segments, each free or busy with an
// owner, and serves one request at a time (clear, add free region, allocate
// with first, best or worst fit, release an owner). one table entry is looked
// at per cycle through a single read port and a shared fit/order judge.
// clear and add write the table in S_EXEC and then fill the result slot;
// allocate scans every entry in S_ASCAN, then takes or splits the chosen
// segment if it can; release sweeps every entry for the owner, then scans
// the whole table once for every free segment visited in ascending start
// order during the merge, plus one more such pass that finds nothing left. ties go
// to the lowest table index. req_i.ready is high only while no request is in
// work; one finished result may wait in the output register while the next
// request is taken
module partition_allocator_fit_unit
  import pafit_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  pafit_req_if.sink     req_i,
  pafit_rsp_if.source   rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_ASCAN,
    S_AFIN,
    S_SPLIT,
    S_RSCAN,
    S_MSCAN,
    S_MSTEP,
    S_DONE
  } state_e;

  state_e           state_q;
  // latched request
  logic [1:0]       op_q;
  logic [1:0]       pol_q;
  logic [OWN_W-1:0] own_q;
  addr_t            sta_q;
  addr_t            size_q;
  // scan
  idx_t             cnt_q;
  logic             have_q;
  idx_t             pick_idx_q;
  addr_t            pick_start_q;
  addr_t            pick_len_q;
  // merge run
  logic             bound_q;
  idx_t             cur_idx_q;
  addr_t            cur_start_q;
  addr_t            cur_len_q;
  addr_t            last_start_q;
  idx_t             last_idx_q;
  // result
  logic [1:0]       res_st_q;
  addr_t            res_addr_q;
  logic             out_vld_q;
  logic [1:0]       out_st_q;
  logic [31:0]      out_addr_q;

  tbl_cmd_t cmd;
  tbl_ent_t ent;
  idx_t     free_idx;
  logic     has_free;
  logic     any_busy;
  logic     take;
  logic     last_ent;
  addr_t    cur_end;

  pafit_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .rd_idx_i   (cnt_q),
    .rd_o       (ent),
    .free_idx_o (free_idx),
    .has_free_o (has_free),
    .any_busy_o (any_busy)
  );

  pafit_judge u_judge (
    .alloc_i      (state_q == S_ASCAN),
    .policy_i     (pol_q),
    .ent_i        (ent),
    .idx_i        (cnt_q),
    .size_i       (size_q),
    .bound_i      (bound_q),
    .last_start_i (last_start_q),
    .last_idx_i   (last_idx_q),
    .have_i       (have_q),
    .pick_start_i (pick_start_q),
    .pick_len_i   (pick_len_q),
    .take_o       (take)
  );

  assign last_ent = (cnt_q == IDX_W'(ENTRIES - 1));
  assign cur_end  = cur_start_q + cur_len_q;

  // table commands per state
  always_comb begin
    cmd          = '0;
    cmd.op       = TC_NONE;
    cmd.owner    = own_q;
    case (state_q)
      S_EXEC: begin
        if (op_q == OP_CLEAR) begin
          cmd.op = TC_CLEAR;
        end else if (op_q == OP_ADD && has_free) begin
          cmd.op    = TC_FILL;
          cmd.idx   = free_idx;
          cmd.busy  = 1'b0;
          cmd.owner = '0;
          cmd.start = sta_q;
          cmd.len   = size_q;
        end
      end
      S_AFIN: begin
        if (have_q && pick_len_q == size_q) begin
          cmd.op  = TC_TAKE;
          cmd.idx = pick_idx_q;
        end else if (have_q && has_free) begin
          // busy piece at the low end of the chosen free segment
          cmd.op    = TC_FILL;
          cmd.idx   = free_idx;
          cmd.busy  = 1'b1;
          cmd.start = pick_start_q;
          cmd.len   = size_q;
        end
      end
      S_SPLIT: begin
        cmd.op    = TC_RESIZE;
        cmd.idx   = pick_idx_q;
        cmd.start = pick_start_q + size_q;
        cmd.len   = pick_len_q - size_q;
      end
      S_RSCAN: begin
        if (ent.valid && ent.busy && ent.owner == own_q) begin
          cmd.op  = TC_FREE;
          cmd.idx = cnt_q;
        end
      end
      S_MSTEP: begin
        if (have_q && bound_q && cur_end == pick_start_q) begin
          cmd.op       = TC_MERGE;
          cmd.idx      = cur_idx_q;
          cmd.drop_idx = pick_idx_q;
          cmd.start    = cur_start_q;
          cmd.len      = cur_len_q + pick_len_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
      have_q    <= 1'b0;
      bound_q   <= 1'b0;
    end else begin
      // the result slot refills itself in S_DONE
      if (out_vld_q && rsp_o.ready && state_q != S_DONE) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          cnt_q  <= '0;
          have_q <= 1'b0;
          case (op_q)
            OP_CLEAR:  state_q <= S_DONE;
            OP_ADD:    state_q <= S_DONE;
            OP_ALLOC:  state_q <= S_ASCAN;
            default:   state_q <= any_busy ? S_RSCAN : S_DONE;
          endcase
        end
        S_ASCAN: begin
          if (take) begin
            have_q <= 1'b1;
          end
          if (last_ent) begin
            state_q <= S_AFIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_AFIN: begin
          if (have_q && pick_len_q != size_q && has_free) begin
            state_q <= S_SPLIT;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_SPLIT: state_q <= S_DONE;
        S_RSCAN: begin
          if (last_ent) begin
            cnt_q   <= '0;
            have_q  <= 1'b0;
            bound_q <= 1'b0;
            state_q <= S_MSCAN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_MSCAN: begin
          if (take) begin
            have_q <= 1'b1;
          end
          if (last_ent) begin
            state_q <= S_MSTEP;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_MSTEP: begin
          cnt_q  <= '0;
          have_q <= 1'b0;
          if (have_q) begin
            bound_q <= 1'b1;
            state_q <= S_MSCAN;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_vld_q || rsp_o.ready) begin
            out_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q   <= req_i.op;
        pol_q  <= req_i.policy;
        own_q  <= req_i.owner;
        sta_q  <= ADDR_BITS'(req_i.start_address);
        size_q <= ADDR_BITS'(req_i.request_size);
      end
      S_EXEC: begin
        res_addr_q <= '0;
        case (op_q)
          OP_CLEAR:   res_st_q <= ST_OK;
          OP_ADD:     res_st_q <= has_free ? ST_OK : ST_FULL;
          OP_ALLOC:   res_st_q <= ST_OK;
          default:    res_st_q <= any_busy ? ST_OK : ST_NOBUSY;
        endcase
      end
      S_ASCAN, S_MSCAN: begin
        if (take) begin
          pick_idx_q   <= cnt_q;
          pick_start_q <= ent.start;
          pick_len_q   <= ent.len;
        end
      end
      S_AFIN: begin
        if (!have_q) begin
          res_st_q <= ST_NOFIT;
        end else if (pick_len_q == size_q || has_free) begin
          res_st_q   <= ST_OK;
          res_addr_q <= pick_start_q;
        end else begin
          res_st_q <= ST_FULL;
        end
      end
      S_MSTEP: begin
        if (have_q) begin
          last_start_q <= pick_start_q;
          last_idx_q   <= pick_idx_q;
          if (bound_q && cur_end == pick_start_q) begin
            // absorb the next free segment into the current run
            cur_len_q <= cur_len_q + pick_len_q;
          end else begin
            cur_idx_q   <= pick_idx_q;
            cur_start_q <= pick_start_q;
            cur_len_q   <= pick_len_q;
          end
        end
      end
      S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_st_q   <= res_st_q;
          out_addr_q <= FLD_W'(res_addr_q);
        end
      end
      default: ;
    endcase
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.status        = out_st_q;
  assign rsp_o.alloc_address = out_addr_q;

endmodule
`default_nettype wire

[tb/pafit_tb_pkg.sv]
package pafit_tb_pkg;
  import pafit_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
  } grant_t;

  // table model and queue of expected grants
  class pafit_scoreboard;
    bit          vld [ENTRIES];
    bit          busy[ENTRIES];
    bit [15:0]   own [ENTRIES];
    bit [31:0]   base[ENTRIES];
    bit [31:0]   len [ENTRIES];
    grant_t      pending_grants[$];
    int          mismatches;
    int          total_requests;

    function void clear_table();
      for (int i = 0; i < ENTRIES; i++) begin
        vld[i] = 0;
        busy[i] = 0;
      end
    endfunction

    function int lowest_empty();
      for (int i = 0; i < ENTRIES; i++)
        if (!vld[i]) return i;
      return -1;
    endfunction

    function grant_t allocate(bit [1:0] pol, bit [15:0] who, bit [31:0] size);
      grant_t g;
      int pick;
      int slot;
      g = '{ST_OK, 32'd0};
      pick = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!vld[i] || busy[i] || len[i] < size) continue;
        if (pick < 0) pick = i;
        else if (pol == POL_BEST) begin
          if (len[i] < len[pick]) pick = i;
        end else if (pol == POL_WORST) begin
          if (len[i] > len[pick]) pick = i;
        end else if (base[i] < base[pick]) pick = i;
      end
      if (pick < 0) begin
        g.status = ST_NOFIT;
        return g;
      end
      if (len[pick] == size) begin
        busy[pick] = 1;
        own[pick] = who;
        g.addr = base[pick];
      end else begin
        slot = lowest_empty();
        if (slot < 0) begin
          g.status = ST_FULL;
          return g;
        end
        vld[slot] = 1;
        busy[slot] = 1;
        own[slot] = who;
        base[slot] = base[pick];
        len[slot] = size;
        g.addr = base[pick];
        base[pick] = base[pick] + size;
        len[pick] = len[pick] - size;
      end
      return g;
    endfunction

    function bit [1:0] release_owner(bit [15:0] who);
      int order[$];
      int cur;
      int pos;
      bit any;
      any = 0;
      for (int i = 0; i < ENTRIES; i++)
        if (vld[i] && busy[i]) any = 1;
      if (!any) return ST_NOBUSY;
      for (int i = 0; i < ENTRIES; i++)
        if (vld[i] && busy[i] && own[i] == who) busy[i] = 0;
      // stable sort of free entries by start
      for (int i = 0; i < ENTRIES; i++) begin
        if (!vld[i] || busy[i]) continue;
        pos = order.size();
        while (pos > 0 && base[order[pos-1]] > base[i]) pos--;
        order.insert(pos, i);
      end
      if (order.size() == 0) return ST_OK;
      cur = order[0];
      for (int k = 1; k < order.size(); k++) begin
        if (base[cur] + len[cur] == base[order[k]]) begin
          len[cur] = len[cur] + len[order[k]];
          vld[order[k]] = 0;
        end else cur = order[k];
      end
      return ST_OK;
    endfunction

    function void note_request(bit [1:0] op, bit [1:0] pol, bit [15:0] who,
                               bit [31:0] sa, bit [31:0] size);
      grant_t g;
      int slot;
      g = '{ST_OK, 32'd0};
      total_requests++;
      case (op)
        OP_CLEAR: clear_table();
        OP_ADD: begin
          slot = lowest_empty();
          if (slot < 0) g.status = ST_FULL;
          else begin
            vld[slot] = 1;
            busy[slot] = 0;
            own[slot] = 0;
            base[slot] = sa;
            len[slot] = size;
          end
        end
        OP_ALLOC: g = allocate(pol, who, size);
        default: g.status = release_owner(who);
      endcase
      pending_grants.push_back(g);
    endfunction

    function void check_grant(bit [1:0] st, bit [31:0] addr);
      grant_t e;
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d addr=%h", st, addr);
        return;
      end
      e = pending_grants.pop_front();
      if (e.status !== st || e.addr !== addr) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status=%0d addr=%h, got status=%0d addr=%h",
                   e.status, e.addr, st, addr);
      end
    endfunction
  endclass
endpackage

[tb/partition_allocator_fit_unit_test.sv]
module partition_allocator_fit_unit_test;
  import pafit_pkg::*;
  import pafit_tb_pkg::*;

  // release can walk the whole table once per free segment
  localparam int IDLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  pafit_req_if req_if();
  pafit_rsp_if rsp_if();

  partition_allocator_fit_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  pafit_scoreboard fit_board = new();
  int   idle_cycles;
  bit   rsp_stall_enable;

  // short gaps mostly, the occasional long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // drive one request, change at falling edge, accept at rising edge
  task automatic send_request(bit [1:0] op, bit [1:0] pol, bit [15:0] who,
                              bit [31:0] sa, bit [31:0] size);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.op <= op;
    req_if.policy <= pol;
    req_if.owner <= who;
    req_if.start_address <= sa;
    req_if.request_size <= size;
    do @(posedge clk_i); while (!req_if.ready);
    fit_board.note_request(op, pol, who, sa, size);
    @(negedge clk_i);
  endtask

  // a well-formed round: carve an area into regions, allocate, release
  task automatic random_round();
    bit [31:0] sa;
    bit [31:0] sz;
    int n;
    if ($urandom_range(0, 3) == 0) send_request(OP_CLEAR, 0, 0, 0, 0);
    n = $urandom_range(1, 6);
    sa = $urandom_range(0, 3) == 0 ? $urandom
                                   : {20'd0, 4'($urandom_range(0, 15)), 8'h00};
    for (int i = 0; i < n; i++) begin
      sz = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 64);
      send_request(OP_ADD, 0, 0, sa, sz);
      // often contiguous so release merges neighbours
      sa = $urandom_range(0, 2) == 0 ? sa + sz + $urandom_range(1, 8) : sa + sz;
    end
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++)
      send_request(OP_ALLOC, 2'($urandom_range(0, 3)),
                   16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)),
                   $urandom, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 40));
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++)
      send_request(OP_RELEASE, 2'($urandom),
                   16'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 3)),
                   $urandom, $urandom);
  endtask

  // result side with random back-pressure
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= rsp_stall_enable ? (pick_gap() == 0) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      fit_board.check_grant(rsp_if.status, rsp_if.alloc_address);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("partition_allocator_fit_unit_test failed");
      $finish;
    end
  end

  // stall toggling: stretches with and without back-pressure
  initial begin
    rsp_stall_enable = 1'b0;
    forever begin
      repeat ($urandom_range(50, 2000)) @(negedge clk_i);
      rsp_stall_enable = ~rsp_stall_enable;
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.op = OP_CLEAR;
    req_if.policy = POL_FIRST;
    req_if.owner = '0;
    req_if.start_address = '0;
    req_if.request_size = '0;
    idle_cycles = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table cases first
    send_request(OP_RELEASE, POL_FIRST, 16'h0000, 0, 0);
    send_request(OP_ALLOC, POL_FIRST, 16'h0001, 0, 32'd1);
    send_request(OP_ADD, POL_FIRST, 0, 32'h0000_0100, 32'd64);
    send_request(OP_ADD, POL_FIRST, 0, 32'h0000_0000, 32'd16);
    send_request(OP_ADD, POL_FIRST, 0, 32'h0000_0200, 32'd32);
    send_request(OP_ADD, POL_FIRST, 0, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_request(OP_ADD, POL_FIRST, 0, 32'h0000_0040, 32'd0);
    send_request(OP_ALLOC, POL_FIRST, 16'hFFFF, 0, 32'd8);      // split, lowest start
    send_request(OP_ALLOC, POL_BEST, 16'h0002, 0, 32'd32);      // exact fit
    send_request(OP_ALLOC, POL_WORST, 16'h0003, 0, 32'd100);    // largest, wraps
    send_request(OP_ALLOC, 2'd3, 16'h0004, 0, 32'd0);           // unused code
    send_request(OP_ALLOC, POL_BEST, 16'h0005, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_RELEASE, POL_FIRST, 16'h7777, 0, 0);        // owner holds nothing
    send_request(OP_RELEASE, POL_FIRST, 16'hFFFF, 0, 0);
    send_request(OP_RELEASE, POL_FIRST, 16'h0002, 0, 0);
    // fill the table to overflow
    for (int i = 0; i < ENTRIES + 1; i++)
      send_request(OP_ADD, POL_FIRST, 0, 32'h1000 + 4 * i, 32'd4);
    send_request(OP_ALLOC, POL_FIRST, 16'h0009, 0, 32'd1);      // split with no slot
    send_request(OP_RELEASE, POL_FIRST, 16'h0003, 0, 0);
    send_request(OP_CLEAR, POL_FIRST, 0, 0, 0);

    while (fit_board.total_requests < 1050) random_round();

    req_if.valid <= 1'b0;
    while (fit_board.pending_grants.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fit_board.mismatches == 0 && fit_board.pending_grants.size() == 0)
      $display("partition_allocator_fit_unit_test passed");
    else
      $display("partition_allocator_fit_unit_test failed");
    $finish;
  end
endmodule
